// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types, constants and codes of the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int MAX_PROC = 64;
  localparam int IDX_W    = $clog2(MAX_PROC);
  localparam int CNT_W    = $clog2(MAX_PROC + 1);
  localparam int TIME_W   = 16;
  localparam int CLK_W    = 23;
  localparam int PNUM_W   = 7;
  localparam int STAT_W   = 3;
  localparam int OP_W     = 2;

  // operation codes of an input word
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // status codes of a result word
  localparam logic [STAT_W-1:0] ST_LOADED = 3'd0;
  localparam logic [STAT_W-1:0] ST_SLICE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_START,
    S_SCAN,
    S_DECIDE,
    S_DISP_RD,
    S_DISP_RD2,
    S_DISP_CALC,
    S_DISP_FIN,
    S_DISP_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec_simple;
    logic scan_start;
    logic scan_step;
    logic admit;
    logic jump;
    logic nothing;
    logic disp_rd;
    logic disp_rd2;
    logic disp_calc;
    logic disp_fin;
    logic disp_wait;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_done;
    logic            found;
    logic            due;
    logic            ring_empty;
    logic            out_free;
  } sts_t;

endpackage

// ===== hdl/rrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer of the scheduler: decode, admission scans, dispatch, result.
// ----------------------------------------------------------------------------
module rrs_ctrl
  import rrs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_valid) state_next = S_DECODE;
      S_DECODE:     state_next = (sts.op == OP_RUN) ? S_SCAN_START : S_RESULT;
      S_SCAN_START: state_next = S_SCAN;
      S_SCAN:       if (sts.scan_done) state_next = S_DECIDE;
      S_DECIDE: begin
        priority if (sts.found && sts.due) state_next = S_SCAN_START;
        else if (sts.ring_empty && !sts.found) state_next = S_RESULT;
        else if (sts.ring_empty) state_next = S_SCAN_START;
        else state_next = S_DISP_RD;
      end
      S_DISP_RD:    state_next = S_DISP_RD2;
      S_DISP_RD2:   state_next = S_DISP_CALC;
      S_DISP_CALC:  state_next = S_DISP_FIN;
      S_DISP_FIN:   state_next = S_DISP_WAIT;
      S_DISP_WAIT:  state_next = S_RESULT;
      S_RESULT:     if (sts.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DECODE:     cmd.exec_simple = (sts.op != OP_RUN);
      S_SCAN_START: cmd.scan_start = 1'b1;
      S_SCAN:       cmd.scan_step = 1'b1;
      S_DECIDE: begin
        // admit a due process, or jump over an idle gap, or give up
        if (sts.found && sts.due) begin
          cmd.admit = 1'b1;
        end else if (sts.ring_empty) begin
          cmd.nothing = !sts.found;
          cmd.jump    = sts.found;
        end
      end
      // advance the ring head once its entry has been read out
      S_DISP_RD:    cmd.disp_rd = 1'b1;
      S_DISP_RD2:   cmd.disp_rd2 = 1'b1;
      S_DISP_CALC:  cmd.disp_calc = 1'b1;
      S_DISP_FIN:   cmd.disp_fin = 1'b1;
      S_DISP_WAIT:  cmd.disp_wait = 1'b1;
      S_RESULT:     cmd.result_load = sts.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== hdl/rrs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_datapath
// Process tables, ready ring, clock, admission scan and result registers.
// ----------------------------------------------------------------------------
module rrs_datapath
  import rrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [OP_W-1:0]   in_op,
  input  logic [TIME_W-1:0] in_arrival,
  input  logic [TIME_W-1:0] in_burst,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_quantum,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [PNUM_W-1:0] out_pnum,
  output logic [CLK_W-1:0]  out_start,
  output logic [CLK_W-1:0]  out_end,
  output logic              out_fin,
  output logic [CLK_W-1:0]  out_ta,
  output logic [CLK_W-1:0]  out_wait
);

  // control state
  logic [CNT_W-1:0]    loaded_count;
  logic [IDX_W-1:0]    ring_head;
  logic [CNT_W-1:0]    ring_count;
  logic [CLK_W-1:0]    current_clock;
  logic [TIME_W-1:0]   quantum;

  // latched input word
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] arr_in;
  logic [TIME_W-1:0] bur_in;

  // scan state
  logic [CNT_W-1:0]  scan_addr;
  logic              pipe_valid;
  logic [IDX_W-1:0]  pipe_idx;
  logic              found;
  logic [TIME_W-1:0] best_arr;
  logic [IDX_W-1:0]  best_idx;

  // dispatch state
  logic [IDX_W-1:0]  proc;
  logic [TIME_W-1:0] arr_q;
  logic [TIME_W-1:0] bur_q;

  // pending result
  logic [STAT_W-1:0] res_status;
  logic [PNUM_W-1:0] res_pnum;
  logic [CLK_W-1:0]  res_start;
  logic [CLK_W-1:0]  res_end;
  logic              res_fin;
  logic [CLK_W-1:0]  res_ta;
  logic [CLK_W-1:0]  res_wait;

  // memory ports
  logic              load_ok;
  logic              arr_we;
  logic [IDX_W-1:0]  arr_raddr;
  logic [TIME_W-1:0] arr_rd;
  logic [TIME_W-1:0] bur_rd;
  logic              rem_we;
  logic [IDX_W-1:0]  rem_waddr;
  logic [TIME_W-1:0] rem_wdata;
  logic [TIME_W-1:0] rem_rd;
  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;
  logic [IDX_W-1:0]  ring_wdata;
  logic [IDX_W-1:0]  ring_rd;
  logic              adm_we;
  logic [IDX_W-1:0]  adm_waddr;
  logic              adm_rd;

  // slice arithmetic
  logic [TIME_W-1:0] q_eff;
  logic [TIME_W-1:0] run_len;
  logic [TIME_W-1:0] rem_new;
  logic [CLK_W-1:0]  clock_after;

  assign load_ok = (op == OP_LOAD) && (loaded_count != CNT_W'(MAX_PROC))
                   && (bur_in != '0);
  assign arr_we  = cmd.exec_simple && load_ok;
  assign arr_raddr = cmd.disp_rd2 ? ring_rd : scan_addr[IDX_W-1:0];

  assign q_eff   = (quantum == '0) ? TIME_W'(1) : quantum;
  assign run_len = (rem_rd < q_eff) ? rem_rd : q_eff;
  assign rem_new = rem_rd - run_len;
  assign clock_after = current_clock + CLK_W'(run_len);

  assign rem_we    = arr_we || cmd.disp_calc;
  assign rem_waddr = cmd.disp_calc ? proc : loaded_count[IDX_W-1:0];
  assign rem_wdata = cmd.disp_calc ? rem_new : bur_in;

  // push admitted process or preempted process at the tail
  assign ring_we    = cmd.admit || (cmd.disp_fin && !res_fin);
  assign ring_waddr = ring_head + ring_count[IDX_W-1:0];
  assign ring_wdata = cmd.admit ? best_idx : proc;

  // mark a process admitted, or clear its flag when it is loaded
  assign adm_we    = arr_we || cmd.admit;
  assign adm_waddr = cmd.admit ? best_idx : loaded_count[IDX_W-1:0];

  rrs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROC)) u_arr (
    .clk(clk), .we(arr_we), .waddr(loaded_count[IDX_W-1:0]), .wdata(arr_in),
    .raddr(arr_raddr), .rdata(arr_rd)
  );

  rrs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROC)) u_bur (
    .clk(clk), .we(arr_we), .waddr(loaded_count[IDX_W-1:0]), .wdata(bur_in),
    .raddr(ring_rd), .rdata(bur_rd)
  );

  rrs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROC)) u_rem (
    .clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(ring_rd), .rdata(rem_rd)
  );

  rrs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROC)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_head), .rdata(ring_rd)
  );

  rrs_ram #(.WIDTH(1), .DEPTH(MAX_PROC)) u_adm (
    .clk(clk), .we(adm_we), .waddr(adm_waddr), .wdata(cmd.admit),
    .raddr(scan_addr[IDX_W-1:0]), .rdata(adm_rd)
  );

  // status to the controller
  always_comb begin
    sts.op         = op;
    sts.scan_done  = (scan_addr == loaded_count) && !pipe_valid;
    sts.found      = found;
    sts.due        = (CLK_W'(best_arr) <= current_clock);
    sts.ring_empty = (ring_count == '0);
    sts.out_free   = !out_valid || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      ring_head     <= '0;
      ring_count    <= '0;
      current_clock <= '0;
      quantum       <= TIME_W'(1);
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_quantum;
      end
      if (cmd.exec_simple) begin
        if (arr_we) begin
          loaded_count <= loaded_count + CNT_W'(1);
        end
        if (op == OP_CLEAR) begin
          loaded_count  <= '0;
          ring_head     <= '0;
          ring_count    <= '0;
          current_clock <= '0;
        end
      end
      if (cmd.admit) begin
        ring_count <= ring_count + CNT_W'(1);
      end
      if (cmd.jump) begin
        current_clock <= CLK_W'(best_arr);
      end
      if (cmd.disp_rd) begin
        ring_head  <= ring_head + IDX_W'(1);
        ring_count <= ring_count - CNT_W'(1);
      end
      if (cmd.disp_calc) begin
        current_clock <= clock_after;
      end
      if (cmd.disp_fin && !res_fin) begin
        ring_count <= ring_count + CNT_W'(1);
      end
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: input latch, scan, dispatch, results
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= in_op;
      arr_in <= in_arrival;
      bur_in <= in_burst;
    end
    if (cmd.scan_start) begin
      scan_addr  <= '0;
      pipe_valid <= 1'b0;
      found      <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (scan_addr < loaded_count) begin
        scan_addr  <= scan_addr + CNT_W'(1);
        pipe_valid <= 1'b1;
        pipe_idx   <= scan_addr[IDX_W-1:0];
      end else begin
        pipe_valid <= 1'b0;
      end
      // keep the earliest pending arrival, first in load order on ties
      if (pipe_valid && !adm_rd && (!found || arr_rd < best_arr)) begin
        found    <= 1'b1;
        best_arr <= arr_rd;
        best_idx <= pipe_idx;
      end
    end
    if (cmd.exec_simple || cmd.nothing) begin
      res_status <= ST_NONE;
      res_pnum   <= '0;
      res_start  <= '0;
      res_end    <= '0;
      res_fin    <= 1'b0;
      res_ta     <= '0;
      res_wait   <= '0;
      if (cmd.exec_simple && op == OP_LOAD) begin
        priority if (loaded_count == CNT_W'(MAX_PROC)) res_status <= ST_FULL;
        else if (bur_in == '0) res_status <= ST_BAD;
        else begin
          res_status <= ST_LOADED;
          res_pnum   <= PNUM_W'(loaded_count) + PNUM_W'(1);
        end
      end
    end
    if (cmd.disp_rd2) begin
      proc <= ring_rd;
    end
    if (cmd.disp_calc) begin
      arr_q      <= arr_rd;
      bur_q      <= bur_rd;
      res_status <= ST_SLICE;
      res_pnum   <= PNUM_W'(proc) + PNUM_W'(1);
      res_start  <= current_clock;
      res_end    <= clock_after;
      res_fin    <= (rem_new == '0);
      res_ta     <= '0;
      res_wait   <= '0;
    end
    if (cmd.disp_fin && res_fin) begin
      res_ta <= res_end - CLK_W'(arr_q);
    end
    if (cmd.disp_wait && res_fin) begin
      res_wait <= res_ta - CLK_W'(bur_q);
    end
    if (cmd.result_load) begin
      out_status <= res_status;
      out_pnum   <= res_pnum;
      out_start  <= res_start;
      out_end    <= res_end;
      out_fin    <= res_fin;
      out_ta     <= res_ta;
      out_wait   <= res_wait;
    end
  end

  // checks
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= loaded_count)
    else $error("ready ring holds more processes than are loaded");

  a_fin_slice: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fin |-> out_status == ST_SLICE)
    else $error("finished flag outside a slice result");

  a_pnum_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_SLICE || out_status == ST_LOADED) |-> out_pnum != '0)
    else $error("served or loaded result carries no process number");

endmodule

// ===== hdl/round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin scheduler over a table of up to 64 loaded processes.
// ----------------------------------------------------------------------------
// One input word is handled at a time. Load, clear and unused ops go from
// decode straight to the result state. For a run word, every admission, and
// an idle-gap clock jump, needs one pass over the loaded entries of the
// arrival table, reading one entry a cycle from its memory port. A finished
// result waits in the output register while the next input word is taken;
// the block stalls only when a second result is ready before the first one
// leaves. No clearing pass is needed after reset.
module round_robin_time_slice_scheduler
  import rrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,       // quantum_length
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // arrival_time[15:0], burst_time[31:16]
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // process_number[6:0], slice_start[29:7],
                                       // slice_end[52:30], finished[53],
                                       // turnaround[76:54], waiting[99:77]
  output logic [2:0]   m_axis_tuser    // status[2:0]
);

  cmd_t cmd;
  sts_t sts;

  logic [PNUM_W-1:0] out_pnum;
  logic [CLK_W-1:0]  out_start;
  logic [CLK_W-1:0]  out_end;
  logic              out_fin;
  logic [CLK_W-1:0]  out_ta;
  logic [CLK_W-1:0]  out_wait;

  assign cfg_ready = 1'b1;

  rrs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  rrs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_axis_tuser), .in_arrival(s_axis_tdata[15:0]),
    .in_burst(s_axis_tdata[31:16]),
    .cfg_we(cfg_valid && cfg_ready), .cfg_quantum(cfg_data),
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
    .out_status(m_axis_tuser), .out_pnum(out_pnum), .out_start(out_start),
    .out_end(out_end), .out_fin(out_fin), .out_ta(out_ta), .out_wait(out_wait)
  );

  // pack the result word
  assign m_axis_tdata = {4'b0, out_wait, out_ta, out_fin, out_end, out_start, out_pnum};

endmodule

// ===== sim/tb_round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_time_slice_scheduler
// Self-checking bench for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
// Words go in on the input stream and predicted slices are queued. A checker
// compares every output word field by field, in order. Directed tests cover
// the load checks, an idle gap, clear, the unused op and quantum extremes.
// Random scheduling runs follow under three idling patterns.
// ----------------------------------------------------------------------------
module tb_round_robin_time_slice_scheduler;
  import rrs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CLK_MASK = (1 << CLK_W) - 1;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [PNUM_W-1:0] pnum;
    logic [CLK_W-1:0]  t_start;
    logic [CLK_W-1:0]  t_end;
    logic              fin;
    logic [CLK_W-1:0]  tat;
    logic [CLK_W-1:0]  wt;
  } slice_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // arrival_time[15:0], burst_time[31:16]
  logic [1:0]   s_axis_tuser;   // op[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;   // process_number, slice_start, slice_end,
                                // finished, turnaround, waiting
  logic [2:0]   m_axis_tuser;   // status[2:0]

  // scheduler mirror
  int unsigned arr_tab [MAX_PROC];
  int unsigned bur_tab [MAX_PROC];
  int unsigned rem_tab [MAX_PROC];
  bit          adm_tab [MAX_PROC];
  int unsigned ring [MAX_PROC];
  int unsigned head, ring_cnt, n_loaded, now, quantum;

  slice_t slice_q [$];
  int     n_fail;
  int     tx_idle, rx_idle;

  round_robin_time_slice_scheduler i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // empty the table, the ring and the clock
  function automatic void wipe_table();
    for (int i = 0; i < MAX_PROC; i++) adm_tab[i] = 1'b0;
    head = 0;
    ring_cnt = 0;
    n_loaded = 0;
    now = 0;
  endfunction

  // move every due process into the ring, earliest arrival first
  function automatic void admit_due();
    bit found;
    int unsigned pick;
    forever begin
      found = 1'b0;
      pick = 0;
      for (int unsigned i = 0; i < n_loaded; i++) begin
        if (!adm_tab[i] && arr_tab[i] <= now && (!found || arr_tab[i] < arr_tab[pick])) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) return;
      adm_tab[pick] = 1'b1;
      ring[(head + ring_cnt) % MAX_PROC] = pick;
      ring_cnt++;
    end
  endfunction

  // work out the result word of one input word and advance the mirror
  function automatic slice_t schedule_word(logic [1:0] op, int unsigned arr,
                                           int unsigned bur);
    slice_t r;
    bit found;
    int unsigned nxt, p, q, run, ta;
    r = '{default: '0};
    r.status = ST_NONE;
    case (op)
      OP_LOAD: begin
        if (n_loaded >= MAX_PROC) r.status = ST_FULL;
        else if (bur == 0) r.status = ST_BAD;
        else begin
          arr_tab[n_loaded] = arr;
          bur_tab[n_loaded] = bur;
          rem_tab[n_loaded] = bur;
          adm_tab[n_loaded] = 1'b0;
          n_loaded++;
          r.status = ST_LOADED;
          r.pnum = PNUM_W'(n_loaded);
        end
      end
      OP_CLEAR: wipe_table();
      OP_RUN: begin
        admit_due();
        if (ring_cnt == 0) begin
          found = 1'b0;
          nxt = 0;
          for (int unsigned i = 0; i < n_loaded; i++) begin
            if (!adm_tab[i] && (!found || arr_tab[i] < nxt)) begin
              nxt = arr_tab[i];
              found = 1'b1;
            end
          end
          if (!found) return r;
          if (nxt > now) now = nxt & CLK_MASK;
          admit_due();
          if (ring_cnt == 0) return r;
        end
        p = ring[head];
        head = (head + 1) % MAX_PROC;
        ring_cnt--;
        q = (quantum == 0) ? 1 : quantum;
        run = (rem_tab[p] < q) ? rem_tab[p] : q;
        r.status = ST_SLICE;
        r.pnum = PNUM_W'(p + 1);
        r.t_start = CLK_W'(now);
        now = (now + run) & CLK_MASK;
        rem_tab[p] -= run;
        r.t_end = CLK_W'(now);
        if (rem_tab[p] == 0) begin
          ta = (now - arr_tab[p]) & CLK_MASK;
          r.fin = 1'b1;
          r.tat = CLK_W'(ta);
          r.wt = CLK_W'(ta - bur_tab[p]);
        end else begin
          ring[(head + ring_cnt) % MAX_PROC] = p;
          ring_cnt++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one input word, predict its result once it is taken
  task automatic send_word(logic [1:0] op, logic [15:0] arr, logic [15:0] bur);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bur, arr};
    do @(posedge clk); while (!s_axis_tready);
    slice_q.push_back(schedule_word(op, 32'(arr), 32'(bur)));
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (slice_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write the quantum with the block idle
  task automatic set_quantum(logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    quantum = 32'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle);

  // compare every result word with the oldest prediction
  always @(posedge clk) begin
    slice_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (slice_q.size() == 0) begin
        $error("unexpected result word, status %0d", m_axis_tuser);
        n_fail++;
      end else begin
        w = slice_q.pop_front();
        if (m_axis_tuser !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_axis_tuser);
          n_fail++;
        end
        if (m_axis_tdata[6:0] !== w.pnum) begin
          $error("process_number: expected %0d, got %0d", w.pnum, m_axis_tdata[6:0]);
          n_fail++;
        end
        if (m_axis_tdata[29:7] !== w.t_start) begin
          $error("slice_start: expected %0d, got %0d", w.t_start, m_axis_tdata[29:7]);
          n_fail++;
        end
        if (m_axis_tdata[52:30] !== w.t_end) begin
          $error("slice_end: expected %0d, got %0d", w.t_end, m_axis_tdata[52:30]);
          n_fail++;
        end
        if (m_axis_tdata[53] !== w.fin) begin
          $error("finished: expected %0d, got %0d", w.fin, m_axis_tdata[53]);
          n_fail++;
        end
        if (m_axis_tdata[76:54] !== w.tat) begin
          $error("turnaround: expected %0d, got %0d", w.tat, m_axis_tdata[76:54]);
          n_fail++;
        end
        if (m_axis_tdata[99:77] !== w.wt) begin
          $error("waiting: expected %0d, got %0d", w.wt, m_axis_tdata[99:77]);
          n_fail++;
        end
      end
    end
  end

  // field extremes, bad burst, unused op and a full table
  task automatic test_load_checks();
    send_word(OP_RUN, 16'h0, 16'h0);
    send_word(OP_LOAD, 16'h0, 16'h0);
    send_word(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_word(OP_LOAD, 16'h0, 16'h1);
    send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_word(OP_RUN, 16'hFFFF, 16'hFFFF);
    send_word(OP_RUN, 16'h0, 16'h0);
    send_word(OP_CLEAR, 16'h0, 16'h0);
    for (int i = 0; i < MAX_PROC; i++)
      send_word(OP_LOAD, 16'($urandom_range(20)), 16'($urandom_range(3, 1)));
    send_word(OP_LOAD, 16'h5, 16'h0);
    send_word(OP_LOAD, 16'h5, 16'h5);
    repeat (8) send_word(OP_RUN, 16'h0, 16'h0);
    send_word(OP_CLEAR, 16'h0, 16'h0);
  endtask

  // gap before the first arrival, ties kept in load order
  task automatic test_idle_gap();
    send_word(OP_LOAD, 16'd100, 16'd7);
    send_word(OP_LOAD, 16'd40, 16'd3);
    send_word(OP_LOAD, 16'd40, 16'd2);
    send_word(OP_LOAD, 16'd300, 16'd1);
    repeat (10) send_word(OP_RUN, 16'h0, 16'h0);
    send_word(OP_CLEAR, 16'h0, 16'h0);
  endtask

  // random scheduling runs: mostly well-formed job sets, some noise
  task automatic test_random(int n_words);
    int sent, k;
    sent = 0;
    while (sent < n_words) begin
      k = $urandom_range(8, 1);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(9) == 0)
          send_word(OP_LOAD, 16'($urandom), 16'($urandom));
        else
          send_word(OP_LOAD, 16'($urandom_range(200)), 16'($urandom_range(40, 1)));
        sent++;
      end
      if ($urandom_range(7) == 0) begin
        send_word(OP_LOAD, 16'($urandom), 16'h0);
        send_word(OP_UNUSED, 16'($urandom), 16'($urandom));
        sent += 2;
      end
      k = $urandom_range(3 * k + 4, k);
      for (int i = 0; i < k; i++) begin
        send_word(OP_RUN, 16'($urandom), 16'($urandom));
        sent++;
      end
      if ($urandom_range(2) == 0) begin
        send_word(OP_CLEAR, 16'($urandom), 16'($urandom));
        sent++;
      end
    end
    send_word(OP_CLEAR, 16'h0, 16'h0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    n_fail = 0;
    tx_idle = 33;
    rx_idle = 68;
    quantum = 1;
    wipe_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_load_checks();
    test_idle_gap();
    set_quantum(16'd65535);
    test_idle_gap();
    set_quantum(16'd0);
    test_idle_gap();
    set_quantum(16'd4);
    test_random(400);
    tx_idle = 68;
    rx_idle = 33;
    set_quantum(16'd1);
    test_random(300);
    tx_idle = 0;
    rx_idle = 0;
    set_quantum(16'd65535);
    test_random(150);
    set_quantum(16'($urandom_range(16, 2)));
    test_random(250);

    drain();
    if (n_fail == 0) begin
      $display("tb_round_robin_time_slice_scheduler passed");
    end else begin
      $display("tb_round_robin_time_slice_scheduler failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #40ms;
    $display("tb_round_robin_time_slice_scheduler failed");
    $finish;
  end

endmodule
